>>> hdl/stack_of_queues_engine_top_macros.svh
// Assertion macros shared by the stack of queues engine RTL
`ifndef STACK_OF_QUEUES_ENGINE_TOP_MACROS_SVH
`define STACK_OF_QUEUES_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SQE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqe assertion failed");
`define SQE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqe assertion failed");
`else
`define SQE_ASSERT_NOW(label, clk, rst, ante, cons)
`define SQE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/sqe_pkg.sv
// Types, constants and helper functions of the stack of queues engine
package sqe_pkg;

  localparam int STACK_LEVELS = 8;
  localparam int QUEUE_SLOTS  = 16;
  localparam int KEY_BITS     = 32;

  localparam int LVL_W  = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
  localparam int HGT_W  = $clog2(STACK_LEVELS + 1);
  localparam int SLOT_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int FILL_W = $clog2(QUEUE_SLOTS + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int CMP_W  = (HGT_W > 3) ? HGT_W : 3;
  localparam int ADDR_W = (STACK_LEVELS * QUEUE_SLOTS > 1) ?
                          $clog2(STACK_LEVELS * QUEUE_SLOTS) : 1;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [2:0] {
    ACT_PUSH    = 3'd0,
    ACT_POP     = 3'd1,
    ACT_ENQ     = 3'd2,
    ACT_DEQ     = 3'd3,
    ACT_CLR_TOP = 3'd4,
    ACT_CLR_ALL = 3'd5,
    ACT_VIEW    = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_STACK_EMPTY = 3'd1,
    ST_STACK_FULL  = 3'd2,
    ST_QUEUE_EMPTY = 3'd3,
    ST_QUEUE_FULL  = 3'd4,
    ST_BAD_DEPTH   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FOLLOW_NONE,
    FOLLOW_POP,
    FOLLOW_DEQ,
    FOLLOW_VIEW
  } follow_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] key_in;
    logic [2:0]         view_depth;
  } sqe_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] key_out;
    logic               last;
    logic [3:0]         levels_used;
    logic [4:0]         top_count;
  } sqe_out_t;

  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [FILL_W-1:0] fill;
  } level_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic pop_fix;
    logic deq_out;
    logic view_step;
  } sqe_cmd_t;

  typedef struct packed {
    follow_t follow;
    logic    view_last;
  } sqe_flag_t;

  function automatic key_t to_key(input logic signed [31:0] k);
    logic [63:0] w;
    w = 64'($unsigned(k));
    return w[KEY_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] from_key(input key_t k);
    logic [63:0] w;
    w = 64'(k);
    return $signed(w[31:0]);
  endfunction

  function automatic logic [3:0] to_levels(input logic [HGT_W-1:0] h);
    logic [15:0] w;
    w = 16'(h);
    return w[3:0];
  endfunction

  function automatic logic [4:0] to_count(input logic [FILL_W-1:0] f);
    logic [15:0] w;
    w = 16'(f);
    return w[4:0];
  endfunction

  // Slot after the given one, wrapping at the end of the ring
  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  // head + offset around the ring; both below QUEUE_SLOTS, so one subtract
  function automatic logic [SLOT_W-1:0] ring_add(input logic [SLOT_W-1:0] s,
                                                 input logic [FILL_W-1:0] n);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(s) + SUM_W'(n);
    if (sum >= SUM_W'(QUEUE_SLOTS)) begin
      sum = sum - SUM_W'(QUEUE_SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] key_addr(input logic [LVL_W-1:0] l,
                                                 input logic [SLOT_W-1:0] s);
    return ADDR_W'(ADDR_W'(l) * ADDR_W'(QUEUE_SLOTS) + ADDR_W'(s));
  endfunction

endpackage

>>> hdl/sqe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module sqe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/sqe_ctrl.sv
// Controller state machine of the stack of queues engine
module sqe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sqe_pkg::sqe_flag_t flags,
  output sqe_pkg::sqe_cmd_t  cmd,
  output logic              busy
);
  import sqe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPFIX,
    S_DEQOUT,
    S_VIEW
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.load      = start;
      S_EXEC:   cmd.exec      = 1'b1;
      S_POPFIX: cmd.pop_fix   = 1'b1;
      S_DEQOUT: cmd.deq_out   = 1'b1;
      S_VIEW:   cmd.view_step = 1'b1;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (flags.follow)
            FOLLOW_POP:  state <= S_POPFIX;
            FOLLOW_DEQ:  state <= S_DEQOUT;
            FOLLOW_VIEW: state <= S_VIEW;
            default:     state <= S_IDLE;
          endcase
        end
        S_POPFIX: state <= S_IDLE;
        S_DEQOUT: state <= S_IDLE;
        S_VIEW: begin
          if (flags.view_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/sqe_datapath.sv
// Datapath of the stack of queues engine: height register, level and key memories, result word
module sqe_datapath (
  input  logic               clk,
  input  logic               rst,
  input  sqe_pkg::sqe_in_t   item,
  input  sqe_pkg::sqe_cmd_t  cmd,
  output sqe_pkg::sqe_flag_t flags,
  output sqe_pkg::sqe_out_t  result,
  output logic               strobe
);
  import sqe_pkg::*;

  logic [HGT_W-1:0]  height;
  logic [HGT_W-1:0]  height_next;
  logic [FILL_W-1:0] top_fill;
  logic [FILL_W-1:0] top_fill_next;
  logic [2:0]        op;
  key_t              key_r;
  logic [2:0]        depth;
  logic [LVL_W-1:0]  lvl;
  logic [SLOT_W-1:0] ptr;
  logic [FILL_W-1:0] cnt;
  logic [FILL_W-1:0] n_view;
  status_t           st;
  follow_t           follow;

  logic [CMP_W-1:0]  load_sel;
  logic [LVL_W-1:0]  load_lvl;

  logic              lv_we;
  logic [LVL_W-1:0]  lv_waddr;
  level_t            lv_wdata;
  logic [LVL_W-1:0]  lv_raddr;
  level_t            lv_rdata;

  logic              key_we;
  logic [ADDR_W-1:0] key_waddr;
  logic [ADDR_W-1:0] key_raddr;
  key_t              key_rdata;

  logic [SLOT_W-1:0] hd;
  logic [FILL_W-1:0] f;
  logic              h_zero;
  logic [FILL_W-1:0] pop_fill;

  assign hd     = lv_rdata.head;
  assign f      = lv_rdata.fill;
  assign h_zero = (height == '0);

  // level addressed by the incoming word: top, or depth below it for a view
  always_comb begin
    load_sel = CMP_W'(height) - CMP_W'(1);
    if (item.action == ACT_VIEW) begin
      load_sel = load_sel - CMP_W'(item.view_depth);
    end
    load_lvl = load_sel[LVL_W-1:0];
  end

  assign lv_raddr = cmd.load ? load_lvl : (lvl - LVL_W'(1));
  assign pop_fill = h_zero ? '0 : f;

  assign flags.follow    = follow;
  assign flags.view_last = ((cnt + FILL_W'(1)) == n_view);

  always_comb begin
    height_next   = height;
    top_fill_next = top_fill;
    st            = ST_OK;
    follow        = FOLLOW_NONE;
    lv_we         = 1'b0;
    lv_waddr      = lvl;
    lv_wdata      = '0;
    key_we        = 1'b0;
    key_waddr     = key_addr(lvl, ring_add(hd, f));
    key_raddr     = key_addr(lvl, ptr);
    case (op)
      ACT_PUSH: begin
        if (height >= HGT_W'(STACK_LEVELS)) begin
          st = ST_STACK_FULL;
        end else begin
          lv_we         = cmd.exec;
          lv_waddr      = height[LVL_W-1:0];
          height_next   = height + HGT_W'(1);
          top_fill_next = '0;
        end
      end
      ACT_POP: begin
        if (h_zero) begin
          st = ST_STACK_EMPTY;
        end else begin
          height_next = height - HGT_W'(1);
          follow      = FOLLOW_POP;
        end
      end
      ACT_ENQ: begin
        if (h_zero) begin
          st = ST_STACK_EMPTY;
        end else if (f >= FILL_W'(QUEUE_SLOTS)) begin
          st = ST_QUEUE_FULL;
        end else begin
          key_we        = cmd.exec;
          lv_we         = cmd.exec;
          lv_wdata      = '{head: hd, fill: f + FILL_W'(1)};
          top_fill_next = f + FILL_W'(1);
        end
      end
      ACT_DEQ: begin
        if (h_zero) begin
          st = ST_STACK_EMPTY;
        end else if (f == '0) begin
          st = ST_QUEUE_EMPTY;
        end else begin
          key_raddr     = key_addr(lvl, hd);
          lv_we         = cmd.exec;
          lv_wdata      = '{head: ring_next(hd), fill: f - FILL_W'(1)};
          top_fill_next = f - FILL_W'(1);
          follow        = FOLLOW_DEQ;
        end
      end
      ACT_CLR_TOP: begin
        if (h_zero) begin
          st = ST_STACK_EMPTY;
        end else if (f == '0) begin
          st = ST_QUEUE_EMPTY;
        end else begin
          lv_we         = cmd.exec;
          top_fill_next = '0;
        end
      end
      ACT_CLR_ALL: begin
        if (h_zero) begin
          st = ST_STACK_EMPTY;
        end else begin
          height_next   = '0;
          top_fill_next = '0;
        end
      end
      ACT_VIEW: begin
        if (h_zero) begin
          st = ST_STACK_EMPTY;
        end else if (CMP_W'(depth) >= CMP_W'(height)) begin
          st = ST_BAD_DEPTH;
        end else if (f == '0) begin
          st = ST_QUEUE_EMPTY;
        end else begin
          // head only on the first fetch; the walk then follows ptr
          if (cmd.exec) begin
            key_raddr = key_addr(lvl, hd);
          end
          follow = FOLLOW_VIEW;
        end
      end
      default: st = ST_OK;
    endcase
  end

  sqe_ram #(
    .WIDTH($bits(level_t)),
    .DEPTH(STACK_LEVELS)
  ) u_level_ram (
    .clk  (clk),
    .we   (lv_we),
    .waddr(lv_waddr),
    .wdata(lv_wdata),
    .raddr(lv_raddr),
    .rdata(lv_rdata)
  );

  sqe_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(STACK_LEVELS * QUEUE_SLOTS)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(key_waddr),
    .wdata(key_r),
    .raddr(key_raddr),
    .rdata(key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      height   <= '0;
      top_fill <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.exec) begin
        height   <= height_next;
        top_fill <= top_fill_next;
        if (follow == FOLLOW_NONE) begin
          strobe <= 1'b1;
        end
      end
      if (cmd.pop_fix) begin
        top_fill <= pop_fill;
        strobe   <= 1'b1;
      end
      if (cmd.deq_out || cmd.view_step) begin
        strobe <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= item.action;
      key_r <= to_key(item.key_in);
      depth <= item.view_depth;
      lvl   <= load_lvl;
    end
    if (cmd.exec) begin
      ptr    <= ring_next(hd);
      cnt    <= FILL_W'(1) - FILL_W'(1);
      n_view <= f;
      result <= '{status: st, key_out: '0, last: 1'b1,
                  levels_used: to_levels(height_next),
                  top_count: to_count(top_fill_next)};
    end
    if (cmd.pop_fix) begin
      result <= '{status: ST_OK, key_out: '0, last: 1'b1,
                  levels_used: to_levels(height), top_count: to_count(pop_fill)};
    end
    if (cmd.deq_out) begin
      result <= '{status: ST_OK, key_out: from_key(key_rdata), last: 1'b1,
                  levels_used: to_levels(height), top_count: to_count(top_fill)};
    end
    if (cmd.view_step) begin
      // emit the word read last cycle, fetch the next slot
      ptr    <= ring_next(ptr);
      cnt    <= cnt + FILL_W'(1);
      result <= '{status: ST_OK, key_out: from_key(key_rdata), last: flags.view_last,
                  levels_used: to_levels(height), top_count: to_count(top_fill)};
    end
  end

endmodule

>>> hdl/stack_of_queues_engine_top.sv
// A word is accepted in S_IDLE and executed in S_EXEC; its result is strobed from the
// strobe register, after S_POPFIX for pop and S_DEQOUT for dequeue. A view strobes its
// n keys on consecutive cycles from S_VIEW. A new word is taken as the last result
// shows, not before; these states follow from the registered reads of the level and key
// memories. Reset empties the stack; the memories are not cleared.
`include "stack_of_queues_engine_top_macros.svh"
module stack_of_queues_engine_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  sqe_pkg::sqe_in_t  item,
  output logic              busy,
  output logic              strobe,
  output sqe_pkg::sqe_out_t result
);
  import sqe_pkg::*;

  sqe_cmd_t  cmd;
  sqe_flag_t flags;

  sqe_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .flags(flags),
    .cmd  (cmd),
    .busy (busy)
  );

  sqe_datapath u_datapath (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cmd   (cmd),
    .flags (flags),
    .result(result),
    .strobe(strobe)
  );

  `SQE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `SQE_ASSERT_NEXT(a_last_ends, clk, rst, strobe && result.last, !strobe)
  `SQE_ASSERT_NEXT(a_view_streams, clk, rst, strobe && !result.last, strobe)
  `SQE_ASSERT_NOW(a_error_single, clk, rst, strobe && (result.status != ST_OK), result.last)
  `SQE_ASSERT_NOW(a_empty_count, clk, rst, strobe && (result.levels_used == 4'd0), result.top_count == 5'd0)

endmodule
